>>> src/rcpe_pkg.sv
// ----------------------------------------------------------------------------
// rcpe_pkg
// Shared codes and constants of the raised-cosine push envelope.
// ----------------------------------------------------------------------------
package rcpe_pkg;

  // register file
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REL_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REL_LENGTH  = 3'd4;

  // phase codes
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RISE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FULL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FALL = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FIN  = 3'd4;

  // amplitude format: Q1.15, 32768 is one
  localparam int unsigned AMP_W = 16;
  localparam logic [AMP_W-1:0] AMP_ONE = 16'd32768;

  // cosine table build, Q30
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q15_HALF    = 64'sd16384;
  localparam longint Q15_ONE     = 64'sd32768;

endpackage

>>> src/raised_cosine_push_envelope_core.sv
// ----------------------------------------------------------------------------
// raised_cosine_push_envelope_core
// Time-to-amplitude envelope: raised-cosine rise, hold, raised-cosine fall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / elapsed_ticks_i) takes one time
//   sample per beat. Output channel (out_valid_o / out_stall_i) returns one
//   beat per sample, in order: amplitude_o in Q1.15 (32768 is one) and
//   phase_code_o (idle, rising, full, falling, finished).
//   Config channel (cfg_valid_i / cfg_ready_o) writes one register per beat;
//   cfg_ready_o is always high. Write only while the pipe is empty.
// Pipeline: one classify stage, one stage per quotient bit of the restoring
//   divider, one index multiply stage, one table read stage, then the output
//   register.
// Throughput: one beat per cycle while the skid entry is empty, set by the
//   fully pipelined divider.
// Reset: registers take their reset values, all valid bits clear, the cosine
//   table is a constant ROM and needs no fill.
// Stall: a two-entry output (register plus skid) absorbs the beat in flight;
//   while the skid entry is full the whole pipe freezes and in_stall_o is
//   high. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module raised_cosine_push_envelope_core #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned COS_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [TIME_BITS-1:0]            cfg_data_i,
  // sample in
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [TIME_BITS-1:0]            elapsed_ticks_i,
  // result out
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcpe_pkg::AMP_W-1:0]      amplitude_o,
  output logic [rcpe_pkg::PHASE_W-1:0]    phase_code_o
);
  import rcpe_pkg::*;

  localparam int unsigned TB     = TIME_BITS;
  localparam int unsigned FB     = PHASE_FRAC_BITS;
  localparam int unsigned IDX_W  = $clog2(2 * COS_TABLE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned PROD_W = FB + IDX_W;
  localparam logic [IDX_W-1:0]  DEPTH_IDX = IDX_W'(COS_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  TWO_DEPTH = IDX_W'(2 * COS_TABLE_DEPTH);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FB - 1);

  // --------------------------------------------------------------------------
  // Quarter-wave cosine ROM, built at elaboration (Q30 Taylor, degree 12)
  // --------------------------------------------------------------------------
  typedef logic [AMP_W-1:0] rom_t [0:COS_TABLE_DEPTH];

  function automatic logic [AMP_W-1:0] cos_entry(input int unsigned k);
    longint ang;
    longint x2;
    longint t;
    longint q;
    ang = (longint'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
    x2  = (ang * ang) / Q30_ONE;
    t   = Q30_ONE;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 132;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 90;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 56;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 30;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 12;
    t   = Q30_ONE - ((x2 * t) / Q30_ONE) / 2;
    if (t < 0) begin
      t = 0;
    end
    q = (t + Q15_HALF) / Q15_ONE;
    if (q > Q15_ONE) begin
      q = Q15_ONE;
    end
    return AMP_W'(q);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k <= COS_TABLE_DEPTH; k++) begin
      r[k] = cos_entry(k);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic          enable_q;
  logic [TB-1:0] push_q, full_q, rel_q, len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      push_q   <= '0;
      full_q   <= '0;
      rel_q    <= '0;
      len_q    <= TB'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE:     enable_q <= cfg_data_i[0];
        REG_PUSH_START: push_q   <= cfg_data_i;
        REG_FULL_START: full_q   <= cfg_data_i;
        REG_REL_START:  rel_q    <= cfg_data_i;
        REG_REL_LENGTH: len_q    <= cfg_data_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe advance: frozen only while the skid entry holds a beat
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_valid_q, out_valid_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Stage 0: classify the sample, pick divider operands
  // --------------------------------------------------------------------------
  logic [TB-1:0]      since_rel;
  logic [TB-1:0]      num_d, den_d;
  logic [PHASE_W-1:0] ph_d;

  always_comb begin
    since_rel = elapsed_ticks_i - rel_q;
    num_d     = elapsed_ticks_i - push_q;
    den_d     = full_q - push_q;
    ph_d      = PH_IDLE;
    if (!enable_q || elapsed_ticks_i < push_q) begin
      ph_d = PH_IDLE;
    end else if (elapsed_ticks_i < full_q) begin
      ph_d = PH_RISE;
    end else if (elapsed_ticks_i < rel_q) begin
      ph_d = PH_FULL;
    end else if (since_rel >= len_q) begin
      ph_d = PH_FIN;
    end else begin
      ph_d  = PH_FALL;
      num_d = since_rel;
      den_d = len_q;
    end
  end

  // per-stage control (stage 0 .. FB)
  logic               vld_q [0:FB];
  logic [PHASE_W-1:0] ph_q  [0:FB];
  // divider data: remainder/divisor into step j, quotient out of step j
  logic [TB-1:0]      rem_q [0:FB-1];
  logic [TB-1:0]      den_q [0:FB-1];
  logic [FB-1:0]      quo_q [1:FB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q[0]  <= ph_d;
      rem_q[0] <= num_d;
      den_q[0] <= den_d;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [TB:0]   sh;
    logic [TB:0]   diff;
    logic          ge;
    logic [FB-1:0] quo_in;

    assign sh   = {rem_q[j], 1'b0};
    assign diff = sh - {1'b0, den_q[j]};
    assign ge   = sh >= {1'b0, den_q[j]};

    if (j == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ph_q[j+1]  <= ph_q[j];
        quo_q[j+1] <= {quo_in[FB-2:0], ge};
      end
    end

    if (j + 1 < FB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[j+1] <= ge ? diff[TB-1:0] : sh[TB-1:0];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Half-wave index: round(u * 2 * depth)
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]  prod;
  logic               vld_m_q;
  logic [PHASE_W-1:0] ph_m_q;
  logic [IDX_W-1:0]   idx_q;

  assign prod = PROD_W'(quo_q[FB]) * PROD_W'(TWO_DEPTH) + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else if (adv) begin
      vld_m_q <= vld_q[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_m_q <= ph_q[FB];
      idx_q  <= prod[PROD_W-1:FB];
    end
  end

  // --------------------------------------------------------------------------
  // Table read: mirror the second quarter, remember the sign
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]   mirror;
  logic [ADDR_W-1:0]  addr;
  logic               vld_r_q;
  logic [PHASE_W-1:0] ph_r_q;
  logic               neg_q;
  logic [AMP_W-1:0]   cos_q;

  assign mirror = TWO_DEPTH - idx_q;
  assign addr   = (idx_q > DEPTH_IDX) ? mirror[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else if (adv) begin
      vld_r_q <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_r_q <= ph_m_q;
      neg_q  <= idx_q > DEPTH_IDX;
      cos_q  <= COS_ROM[addr];
    end
  end

  // --------------------------------------------------------------------------
  // Amplitude: half of (one -/+ cos), rounded up
  // --------------------------------------------------------------------------
  logic [AMP_W:0]   up_sum, dn_sum;
  logic [AMP_W-1:0] amp_d;

  always_comb begin
    // one - cos and one + cos, each plus one for the round-up
    up_sum = {1'b0, AMP_ONE} + {1'b0, cos_q} + (AMP_W+1)'(1);
    dn_sum = {1'b0, AMP_ONE} - {1'b0, cos_q} + (AMP_W+1)'(1);
    case (ph_r_q)
      PH_RISE: amp_d = neg_q ? up_sum[AMP_W:1] : dn_sum[AMP_W:1];
      PH_FALL: amp_d = neg_q ? dn_sum[AMP_W:1] : up_sum[AMP_W:1];
      PH_FULL: amp_d = AMP_ONE;
      default: amp_d = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register plus skid entry
  // --------------------------------------------------------------------------
  logic               take_out;
  logic [AMP_W-1:0]   out_amp_q, skid_amp_q;
  logic [PHASE_W-1:0] out_ph_q, skid_ph_q;

  assign take_out = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take_out) begin
      out_valid_q  <= skid_valid_q || vld_r_q;
      skid_valid_q <= 1'b0;
    end else if (adv && vld_r_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_amp_q <= skid_valid_q ? skid_amp_q : amp_d;
      out_ph_q  <= skid_valid_q ? skid_ph_q  : ph_r_q;
    end else if (adv) begin
      skid_amp_q <= amp_d;
      skid_ph_q  <= ph_r_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign amplitude_o  = out_amp_q;
  assign phase_code_o = out_ph_q;

`ifndef SYNTHESIS
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without an output stall");

  a_amp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_amp_q <= AMP_ONE)
    else $error("amplitude above one");

  a_flat_phases : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_ph_q == PH_IDLE || out_ph_q == PH_FIN) |-> out_amp_q == '0)
    else $error("nonzero amplitude while idle or finished");

  a_full_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ph_q == PH_FULL |-> out_amp_q == AMP_ONE)
    else $error("full phase without unit amplitude");
`endif

endmodule

>>> tb/tb_raised_cosine_push_envelope_core.sv
// ----------------------------------------------------------------------------
// tb_raised_cosine_push_envelope_core
// Self-checking bench: register writes, envelope phases, output backpressure.
// Each accepted time sample is run through a local envelope predictor and the
// result is queued; every output beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_raised_cosine_push_envelope_core;
  import rcpe_pkg::*;

  localparam int TIME_W    = 32;
  localparam int COS_DEPTH = 1024;
  localparam int FRAC_W    = 16;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 12;
  // classify + one stage per quotient bit + index + table + output register
  localparam int LATENCY         = FRAC_W + 3;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int WATCHDOG_CYCLES = 400_000;

  // one expected output beat, with the sample that caused it for messages
  typedef struct packed {
    logic [TIME_W-1:0]  ticks;
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
  } envelope_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = REG_ENABLE;
  logic [TIME_W-1:0]    cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [TIME_W-1:0]    elapsed_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [AMP_W-1:0]     amplitude_o;
  logic [PHASE_W-1:0]   phase_code_o;

  raised_cosine_push_envelope_core #(
    .TIME_BITS      (TIME_W),
    .COS_TABLE_DEPTH(COS_DEPTH),
    .PHASE_FRAC_BITS(FRAC_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .elapsed_ticks_i(elapsed_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .amplitude_o    (amplitude_o),
    .phase_code_o   (phase_code_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow copy of the register file plus the cosine ROM
  // --------------------------------------------------------------------------
  logic              env_enable     = 1'b0;
  logic [TIME_W-1:0] env_push_start = '0;
  logic [TIME_W-1:0] env_full_start = '0;
  logic [TIME_W-1:0] env_rel_start  = '0;
  logic [TIME_W-1:0] env_rel_length = 32'd1;

  logic [AMP_W-1:0]  cos_rom [0:COS_DEPTH];

  envelope_t         pending_q [$];
  int unsigned       error_count     = 0;
  bit                no_idle         = 1'b0;  // both sides run without gaps
  int unsigned       hold_off_cycles = 0;     // one-shot long stall request

  // Quarter-wave cosine in Q1.15. Angle k*pi/(2*DEPTH) in Q30, degree-12
  // Taylor series by Horner with truncating products, rounded half up.
  initial begin : build_cos_rom
    longint ang, x2, acc, q;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      ang = (longint'(k) * HALF_PI_Q30) / COS_DEPTH;
      x2  = (ang * ang) / Q30_ONE;
      acc = Q30_ONE;
      for (int n = 6; n >= 1; n--)
        acc = Q30_ONE - ((x2 * acc) / Q30_ONE) / longint'((2 * n) * (2 * n - 1));
      if (acc < 0) acc = 0;
      q = (acc + Q15_HALF) / Q15_ONE;
      if (q > Q15_ONE) q = Q15_ONE;
      cos_rom[k] = q[AMP_W-1:0];
    end
  end

  // floor(num * 2^FRAC_W / den), restoring division; caller keeps num < den
  function automatic logic [FRAC_W-1:0] ramp_fraction(input logic [TIME_W-1:0] num,
                                                      input logic [TIME_W-1:0] den);
    logic [TIME_W+1:0] rem;
    logic [FRAC_W-1:0] quo;
    rem = num;
    quo = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(pi*u) in Q1.15 from the quarter-wave ROM, nearest half-wave index
  function automatic int half_wave_cos(input logic [FRAC_W-1:0] u);
    longint unsigned idx;
    idx = (64'(u) * (2 * COS_DEPTH) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
    if (idx > 2 * COS_DEPTH) idx = 2 * COS_DEPTH;
    if (idx <= COS_DEPTH) return int'(cos_rom[idx]);
    return -int'(cos_rom[2 * COS_DEPTH - idx]);
  endfunction

  function automatic envelope_t envelope_at(input logic [TIME_W-1:0] t);
    envelope_t r;
    int        c;
    r.ticks = t;
    if (!env_enable || t < env_push_start) begin
      r.amp   = '0;
      r.phase = PH_IDLE;
    end else if (t < env_full_start) begin
      c       = half_wave_cos(ramp_fraction(t - env_push_start,
                                            env_full_start - env_push_start));
      r.amp   = AMP_W'((int'(AMP_ONE) - c + 1) >>> 1);
      r.phase = PH_RISE;
    end else if (t < env_rel_start) begin
      r.amp   = AMP_ONE;
      r.phase = PH_FULL;
    end else if (t - env_rel_start >= env_rel_length) begin
      // compare by difference so a fall ending past the tick range can't wrap
      r.amp   = '0;
      r.phase = PH_FIN;
    end else begin
      c       = half_wave_cos(ramp_fraction(t - env_rel_start, env_rel_length));
      r.amp   = AMP_W'((int'(AMP_ONE) + c + 1) >>> 1);
      r.phase = PH_FALL;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Drivers. All pins move by NBA at a rising edge; handshakes are sampled in
  // the active region right after the edge, i.e. the pre-edge values.
  // --------------------------------------------------------------------------

  // cfg_valid_i stays high so back-to-back writes need no drop; callers lower
  // it once the last write of a group is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ENABLE:     env_enable     = data[0];
      REG_PUSH_START: env_push_start = data;
      REG_FULL_START: env_full_start = data;
      REG_REL_START:  env_rel_start  = data;
      REG_REL_LENGTH: env_rel_length = data;
      default: ;  // unmapped index, write is dropped
    endcase
  endtask

  task automatic program_envelope(input logic en, input logic [TIME_W-1:0] push,
                                  input logic [TIME_W-1:0] full,
                                  input logic [TIME_W-1:0] rel,
                                  input logic [TIME_W-1:0] len);
    write_reg(REG_ENABLE, {{(TIME_W-1){1'b0}}, en});
    write_reg(REG_PUSH_START, push);
    write_reg(REG_FULL_START, full);
    write_reg(REG_REL_START, rel);
    write_reg(REG_REL_LENGTH, len);
    cfg_valid_i <= 1'b0;
  endtask

  // Valid is lowered only ahead of a gap, so a zero-gap follow-on beat never
  // sees a drop and a raise in the same step.
  task automatic send_sample(input logic [TIME_W-1:0] ticks);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    elapsed_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(envelope_at(ticks));
  endtask

  // Every sample yields one beat, so an empty queue means an empty pipe and
  // registers may be rewritten.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] pick_span();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2, 3:    return $urandom_range(2, 64);
      4, 5:    return $urandom_range(65, 100_000);
      6:       return $urandom();
      default: return '1;
    endcase
  endfunction

  // Mostly near the phase edges or inside push..end of fall; some anywhere.
  function automatic logic [TIME_W-1:0] pick_ticks();
    logic [TIME_W-1:0] lo, hi;
    lo = env_push_start;
    hi = env_rel_start + env_rel_length;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return env_push_start + $urandom_range(0, 16) - 8;
      3:       return env_full_start + $urandom_range(0, 16) - 8;
      4:       return env_rel_start + $urandom_range(0, 16) - 8;
      5:       return hi + $urandom_range(0, 16) - 8;
      default: return (hi > lo) ? lo + $urandom_range(0, hi - lo) : $urandom();
    endcase
  endfunction

  task automatic program_random_envelope();
    logic              en;
    logic [TIME_W-1:0] push, full, rel, len;
    en = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 5))
      0: begin  // any order at all
        push = $urandom();
        full = $urandom();
        rel  = $urandom();
        len  = $urandom();
      end
      1: begin  // register extremes
        push = $urandom_range(0, 1) ? '1 : '0;
        full = $urandom_range(0, 1) ? '1 : '0;
        rel  = $urandom_range(0, 1) ? '1 : '0;
        len  = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin  // well-formed rise / hold / fall
        push = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
        full = push + pick_span();
        rel  = full + pick_span();
        len  = pick_span();
      end
    endcase
    program_envelope(en, push, full, rel, len);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset file: disabled gives idle; enabled with all ticks zero and a fall of
  // one tick gives the top of the fall at zero and finished one tick later.
  task automatic test_reset_values();
    send_sample('0);
    send_sample('1);
    drain_pipe();
    write_reg(REG_ENABLE, 32'd1);
    cfg_valid_i <= 1'b0;
    send_sample('0);
    send_sample(32'd1);
    drain_pipe();
  endtask

  // Writes to unmapped indexes with all-ones data must leave the file alone.
  task automatic test_ignored_indexes();
    for (int i = REG_REL_LENGTH + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], '1);
    cfg_valid_i <= 1'b0;
    send_sample('0);
    send_sample(32'd1);
    drain_pipe();
  endtask

  // Ordinary envelope: each phase and both edges of each ramp.
  task automatic test_envelope_shape();
    program_envelope(1'b1, 32'd100, 32'd1100, 32'd5000, 32'd2000);
    send_sample(32'd99);
    send_sample(32'd100);
    send_sample(32'd600);
    send_sample(32'd1100);
    send_sample(32'd5000);
    send_sample(32'd6999);
    send_sample(32'd7000);
    send_sample('1);
    drain_pipe();
  endtask

  task automatic test_corner_timings();
    // zero-length rise and zero-length fall: no division on either ramp
    program_envelope(1'b1, 32'd10, 32'd10, 32'd20, 32'd0);
    send_sample(32'd9);
    send_sample(32'd10);
    send_sample(32'd20);
    drain_pipe();
    // release before full: the fall takes over from full_start on
    program_envelope(1'b1, 32'd0, 32'd1000, 32'd500, 32'd1000);
    send_sample(32'd999);
    send_sample(32'd1000);
    send_sample(32'd1499);
    send_sample(32'd1500);
    drain_pipe();
    // widest rise, fall end far past the top of the tick range
    program_envelope(1'b1, '0, '1, '1, '1);
    send_sample('0);
    send_sample(32'hFFFF_FFFE);
    send_sample('1);
    drain_pipe();
  endtask

  // Random register settings, each followed by a burst of samples; every
  // fourth setting runs both sides flat out.
  task automatic test_random_envelopes();
    for (int phase = 0; phase < 10; phase++) begin
      program_random_envelope();
      no_idle = (phase % 4 == 3);
      repeat (100) send_sample(pick_ticks());
      drain_pipe();
    end
    no_idle = 1'b0;
  endtask

  // Sink freezes for a long stretch while the source keeps pushing, so the
  // pipe and skid fill and the input must stall without dropping a beat.
  task automatic test_output_backpressure();
    program_envelope(1'b1, 32'd0, 32'd64, 32'd128, 32'd64);
    no_idle         = 1'b1;
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (60) send_sample(pick_ticks());
    drain_pipe();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sink: random stall before each beat, or a one-shot long hold when asked
  // --------------------------------------------------------------------------
  initial begin : sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_cycles != 0) begin
        hold            = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (no_idle) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Scoreboard: each taken beat against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    envelope_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("beat with no sample pending: amp %0d phase %0d",
                                  amplitude_o, phase_code_o));
      end else begin
        want = pending_q.pop_front();
        if (amplitude_o !== want.amp)
          report_mismatch($sformatf("ticks 0x%08h amplitude %0d, want %0d",
                                    want.ticks, amplitude_o, want.amp));
        if (phase_code_o !== want.phase)
          report_mismatch($sformatf("ticks 0x%08h phase %0d, want %0d",
                                    want.ticks, phase_code_o, want.phase));
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("watchdog expired with %0d results outstanding", pending_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_ignored_indexes();
    test_envelope_shape();
    test_corner_timings();
    test_random_envelopes();
    test_output_backpressure();

    // all expected beats are in; give a stray extra beat time to show up
    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
